// ===== sv/assert_macros.svh =====
// Assertion macros shared by the sequencer RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/tfs_pkg.sv =====
// Shared types and constants of the timestamp frame sequencer.
package tfs_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int STAMP_W         = 64;
	localparam int FRAME_W         = 10;
	localparam int COUNT_OUT_W     = 11;
	localparam int STATUS_W        = 2;
	localparam int CMD_W           = 3;
	localparam int IN_TDATA_W      = 80;
	localparam int OUT_TDATA_W     = 152;

	// Command codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 3'd0,
		CMD_CLEAR = 3'd1,
		CMD_TICK  = 3'd2,
		CMD_SEEK  = 3'd3,
		CMD_NEXT  = 3'd4,
		CMD_PREV  = 3'd5,
		CMD_SET   = 3'd6
	} cmd_t;

	// Status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_FRAME = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_LOOPED = 1'b0;
	localparam logic CFG_PAUSED = 1'b1;

	// Status of the iterative remainder unit.
	typedef struct packed {
		logic busy;
		logic done;
	} rem_stat_t;

endpackage

// ===== sv/tfs_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module tfs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== sv/tfs_rem.sv =====
// Iterative restoring remainder unit, one dividend bit per cycle.
`include "assert_macros.svh"

module tfs_rem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tfs_pkg::STAMP_W-1:0]  dividend,
	input  logic [tfs_pkg::STAMP_W-1:0]  divisor,
	output tfs_pkg::rem_stat_t           stat,
	output logic [tfs_pkg::STAMP_W-1:0]  remainder
);

	localparam int W     = tfs_pkg::STAMP_W;
	localparam int CNT_W = $clog2(W);

	logic [W-1:0]     n_q;
	logic [W-1:0]     d_q;
	logic [W-1:0]     rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W:0]       trial;
	logic [W:0]       nxt;

	// One compare and subtract step of the long division.
	always_comb begin
		trial = {rem_q, n_q[W-1]};
		if (trial >= {1'b0, d_q}) begin
			nxt = trial - {1'b0, d_q};
		end else begin
			nxt = trial;
		end
	end

	// Control: count the steps and flag the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and the dividend bits still to shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= dividend;
			d_q   <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			n_q   <= {n_q[W-2:0], 1'b0};
			rem_q <= nxt[W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;

	// While the unit is busy, the partial remainder stays below the divisor.
	`ASSERT_IMPLIES(a_rem_below_divisor, clk, arst_n, busy_q, rem_q < d_q)

endmodule

// ===== sv/timestamp_frame_sequencer.sv =====
// Timestamp frame sequencer: command decode, play timer and table search.
// The block keeps up to TABLE_DEPTH frame timestamps in a single-port-read RAM and
// answers every command with one result transaction. Load, clear and rejected
// commands need no RAM read; next, previous and set frame do one RAM read to
// fetch the new frame's offset. Seek and tick run a linear search through the
// table, one entry per cycle. Seek starts at frame 0. A tick starts at the
// current frame, or at frame 0 when the timer moved back. They visit at most
// TABLE_DEPTH entries. A looped tick whose timer passes the duration first
// waits for the iterative remainder unit. The table needs no clearing after
// reset; only entries below the entry count are read.
// The input is not ready from acceptance until the result is in the output
// register; one finished result may wait there while the next command runs.
`include "assert_macros.svh"

module timestamp_frame_sequencer #(
	parameter int TABLE_DEPTH = tfs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic                              cfg_data,
	// Command stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// command [2:0], amount_ns [66:3], frame_select [76:67], zero pad
	input  logic [tfs_pkg::IN_TDATA_W-1:0]    s_tdata,
	// Result stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// frame_index [9:0], timer_ns [73:10], frame_offset_ns [137:74],
	// entry_count [148:138], status [150:149], zero pad
	output logic [tfs_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	localparam int W  = tfs_pkg::STAMP_W;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_EXEC  = 9'b000000010,
		ST_TICK  = 9'b000000100,
		ST_MOD   = 9'b000001000,
		ST_SETUP = 9'b000010000,
		ST_SCAN  = 9'b000100000,
		ST_FETCH = 9'b001000000,
		ST_FWAIT = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t                          state_q;
	tfs_pkg::cmd_t                   cmd_q;
	logic [W-1:0]                    amount_q;
	logic [tfs_pkg::FRAME_W-1:0]     sel_q;
	logic [CW-1:0]                   count_q;
	logic [AW-1:0]                   cur_q;
	logic [W-1:0]                    timer_q;
	logic [W-1:0]                    cur_off_q;
	logic [W-1:0]                    first_q;
	logic [W-1:0]                    last_q;
	logic [W-1:0]                    dur_q;
	logic                            looped_q;
	logic                            paused_q;
	logic [tfs_pkg::STATUS_W-1:0]    status_q;
	logic                            from_zero_q;
	logic [CW-1:0]                   idx_q;
	logic [AW-1:0]                   cmp_idx_q;
	logic                            pend_q;
	logic [AW-1:0]                   found_q;
	logic [W-1:0]                    found_off_q;
	logic                            m_tvalid_q;
	logic [tfs_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	logic                            ram_we;
	logic                            ram_re;
	logic [AW-1:0]                   ram_raddr;
	logic [W-1:0]                    ram_rdata;
	logic                            rem_start;
	tfs_pkg::rem_stat_t              rem_stat;
	logic [W-1:0]                    rem_value;
	logic [W:0]                      tick_sum;
	logic [W-1:0]                    scan_off;
	logic                            scan_issue;
	logic                            scan_break;
	logic                            table_full;

	assign table_full = (count_q == CW'(TABLE_DEPTH));
	assign tick_sum   = {1'b0, timer_q} + {1'b0, amount_q};
	assign scan_off   = ram_rdata - first_q;
	assign scan_issue = (idx_q < count_q);
	assign scan_break = pend_q && (scan_off > timer_q);

	// Table memory accesses.
	assign ram_we    = (state_q == ST_EXEC) && (cmd_q == tfs_pkg::CMD_LOAD) && !table_full;
	assign ram_re    = (state_q == ST_FETCH) || ((state_q == ST_SCAN) && scan_issue);
	assign ram_raddr = (state_q == ST_FETCH) ? cur_q : idx_q[AW-1:0];

	tfs_ram #(
		.WIDTH (W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (amount_q),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// Remainder unit for the looped timer wrap.
	assign rem_start = (state_q == ST_TICK) && (dur_q != '0) && looped_q && (timer_q > dur_q);

	tfs_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (timer_q - W'(1)),
		.divisor   (dur_q),
		.stat      (rem_stat),
		.remainder (rem_value)
	);

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			looped_q <= 1'b0;
			paused_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tfs_pkg::CFG_LOOPED: looped_q <= cfg_data;
				tfs_pkg::CFG_PAUSED: paused_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cur_q       <= '0;
			timer_q     <= '0;
			cur_off_q   <= '0;
			pend_q      <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			// Output valid: set when a result is loaded, cleared when it is taken.
			if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (cmd_q)
						tfs_pkg::CMD_LOAD: begin
							state_q <= ST_DONE;
							if (!table_full) begin
								count_q   <= count_q + CW'(1);
								timer_q   <= '0;
								cur_q     <= '0;
								cur_off_q <= '0;
							end
						end
						tfs_pkg::CMD_CLEAR: begin
							state_q   <= ST_DONE;
							count_q   <= '0;
							timer_q   <= '0;
							cur_q     <= '0;
							cur_off_q <= '0;
						end
						tfs_pkg::CMD_TICK: begin
							if (!paused_q && count_q != '0 && amount_q != '0) begin
								timer_q <= tick_sum[W] ? '1 : tick_sum[W-1:0];
								state_q <= ST_TICK;
							end else begin
								state_q <= ST_DONE;
							end
						end
						tfs_pkg::CMD_SEEK: begin
							if (count_q != '0) begin
								timer_q <= amount_q;
								state_q <= ST_SETUP;
							end else begin
								state_q <= ST_DONE;
							end
						end
						tfs_pkg::CMD_NEXT: begin
							if (count_q != '0) begin
								if ((CW'(cur_q) + CW'(1)) == count_q) begin
									cur_q <= '0;
								end else begin
									cur_q <= cur_q + AW'(1);
								end
								state_q <= ST_FETCH;
							end else begin
								state_q <= ST_DONE;
							end
						end
						tfs_pkg::CMD_PREV: begin
							if (count_q != '0) begin
								if (cur_q == '0) begin
									cur_q <= AW'(count_q - CW'(1));
								end else begin
									cur_q <= cur_q - AW'(1);
								end
								state_q <= ST_FETCH;
							end else begin
								state_q <= ST_DONE;
							end
						end
						tfs_pkg::CMD_SET: begin
							if (32'(sel_q) < 32'(count_q)) begin
								cur_q   <= AW'(sel_q);
								state_q <= ST_FETCH;
							end else begin
								state_q <= ST_DONE;
							end
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_TICK: begin
					if (dur_q == '0) begin
						state_q <= ST_SETUP;
					end else if (looped_q) begin
						state_q <= (timer_q > dur_q) ? ST_MOD : ST_SETUP;
					end else if (timer_q >= dur_q) begin
						timer_q   <= dur_q;
						cur_q     <= AW'(count_q - CW'(1));
						cur_off_q <= dur_q;
						state_q   <= ST_DONE;
					end else begin
						state_q <= ST_SETUP;
					end
				end
				ST_MOD: begin
					if (rem_stat.done) begin
						timer_q <= rem_value + W'(1);
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					pend_q <= 1'b0;
					if (timer_q == '0) begin
						cur_q     <= '0;
						cur_off_q <= '0;
						state_q   <= ST_DONE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					pend_q <= scan_issue && !scan_break;
					if (scan_break || (!scan_issue && !pend_q)) begin
						cur_q     <= found_q;
						cur_off_q <= found_off_q;
						state_q   <= ST_DONE;
					end
				end
				ST_FETCH: begin
					state_q <= ST_FWAIT;
				end
				ST_FWAIT: begin
					cur_off_q <= ram_rdata - first_q;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers of the sequencer.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			cmd_q    <= tfs_pkg::cmd_t'(s_tdata[2:0]);
			amount_q <= s_tdata[66:3];
			sel_q    <= s_tdata[76:67];
			status_q <= tfs_pkg::STATUS_OK;
		end
		if (state_q == ST_EXEC) begin
			dur_q       <= last_q - first_q;
			from_zero_q <= (cmd_q == tfs_pkg::CMD_SEEK);
			if (cmd_q == tfs_pkg::CMD_LOAD) begin
				if (table_full) begin
					status_q <= tfs_pkg::STATUS_FULL;
				end else begin
					last_q <= amount_q;
					if (count_q == '0) begin
						first_q <= amount_q;
					end
				end
			end
			if (cmd_q == tfs_pkg::CMD_SET && !(32'(sel_q) < 32'(count_q))) begin
				status_q <= tfs_pkg::STATUS_BAD_FRAME;
			end
		end
		// Search start: the current frame, or frame 0 when the timer went back.
		if (state_q == ST_SETUP) begin
			if (from_zero_q || cur_off_q > timer_q) begin
				found_q     <= '0;
				found_off_q <= '0;
				idx_q       <= CW'(1);
			end else begin
				found_q     <= cur_q;
				found_off_q <= cur_off_q;
				idx_q       <= CW'(cur_q) + CW'(1);
			end
		end
		// Scan: issue one read per cycle and check the previous read's offset.
		if (state_q == ST_SCAN) begin
			if (scan_issue) begin
				idx_q     <= idx_q + CW'(1);
				cmp_idx_q <= idx_q[AW-1:0];
			end
			if (pend_q && !scan_break) begin
				found_q     <= cmp_idx_q;
				found_off_q <= scan_off;
			end
		end
		if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {1'b0, status_q, tfs_pkg::COUNT_OUT_W'(count_q), cur_off_q, timer_q,
				tfs_pkg::FRAME_W'(cur_q)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// The entry count never passes the table depth.
	`ASSERT_ALWAYS(a_count_bounded, clk, arst_n, count_q <= CW'(TABLE_DEPTH))
	// With a non-empty table the current frame is always a held entry.
	`ASSERT_IMPLIES(a_frame_held, clk, arst_n, count_q != '0, CW'(cur_q) < count_q)
	// An empty table has frame 0, offset 0 and a stopped timer.
	`ASSERT_IMPLIES(a_empty_state, clk, arst_n, count_q == '0,
		cur_q == '0 && timer_q == '0 && cur_off_q == '0)
	// While the wrap waits for its remainder, the remainder unit is running.
	`ASSERT_IMPLIES(a_mod_busy, clk, arst_n, state_q == ST_MOD && !rem_stat.done, rem_stat.busy)

endmodule

// ===== sim/tb_timestamp_frame_sequencer.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the timestamp frame sequencer with a cycle-free predictor.
module tb_timestamp_frame_sequencer;
	import tfs_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int QUIET_LIMIT = 20000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 40;
	localparam int BIG_LOADS = 200;
	localparam logic [CMD_W-1:0] CMD_NOP = 3'd7;
	localparam logic [STAMP_W-1:0] MAX_NS = {STAMP_W{1'b1}};
	// Register settings of the random phases, phase 0 in bit 0.
	localparam bit [RANDOM_PHASES-1:0] LOOP_PLAN = 6'b010110;
	localparam bit [RANDOM_PHASES-1:0] PAUSE_PLAN = 6'b001100;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [STAMP_W-1:0] amount_ns;
		logic [FRAME_W-1:0] frame_select;
	} seq_cmd_t;

	typedef struct packed {
		logic [FRAME_W-1:0]     frame_index;
		logic [STAMP_W-1:0]     timer_ns;
		logic [STAMP_W-1:0]     frame_offset_ns;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic [STATUS_W-1:0]    status;
	} seq_result_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic                   cfg_index = 1'b0;
	logic                   cfg_data = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// Commands waiting to be sent and results waiting to be seen.
	seq_cmd_t    cmd_q [$];
	seq_result_t result_q [$];
	int          errors = 0;
	int          quiet_cycles = 0;

	// Predicted sequencer state.
	logic [STAMP_W-1:0] pred_stamps [DEPTH];
	int unsigned        pred_count = 0;
	int unsigned        pred_frame = 0;
	logic [STAMP_W-1:0] pred_timer = '0;
	bit                 pred_looped = 1'b0;
	bit                 pred_paused = 1'b0;

	timestamp_frame_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Clock generation.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Offset of a frame from the first timestamp, wrapping modulo 2^64.
	function automatic logic [STAMP_W-1:0] frame_offset(int unsigned idx);
		if (pred_count == 0) return '0;
		if (idx >= pred_count) idx = pred_count - 1;
		return pred_stamps[idx] - pred_stamps[0];
	endfunction

	// Last frame whose offset does not exceed the timer, scanning up from start.
	function automatic int unsigned find_frame(logic [STAMP_W-1:0] t, int unsigned start);
		int unsigned found;
		int unsigned i;
		if (pred_count == 0 || t == 0) return 0;
		if (start >= pred_count) start = 0;
		if (frame_offset(start) > t) start = 0;
		found = start;
		for (i = start; i < pred_count; i++) begin
			if (frame_offset(i) > t) break;
			found = i;
		end
		return found;
	endfunction

	// Timer advance with saturation, loop wrap or clamp at the last frame.
	function automatic void advance_timer(logic [STAMP_W-1:0] delta);
		logic [STAMP_W-1:0] dur;
		int unsigned start;
		if (pred_paused || pred_count == 0 || delta == 0) return;
		dur = frame_offset(pred_count - 1);
		if (pred_timer > MAX_NS - delta) pred_timer = MAX_NS;
		else pred_timer = pred_timer + delta;
		start = pred_frame;
		if (dur > 0) begin
			if (pred_looped) begin
				if (pred_timer > dur) pred_timer = ((pred_timer - 64'd1) % dur) + 64'd1;
				if (pred_timer < frame_offset(pred_frame)) start = 0;
			end else if (pred_timer >= dur) begin
				pred_timer = dur;
				pred_frame = pred_count - 1;
				return;
			end
		end
		pred_frame = find_frame(pred_timer, start);
	endfunction

	// Applies one command to the predicted state and returns the expected result.
	function automatic seq_result_t apply_command(seq_cmd_t c);
		seq_result_t r;
		logic [STATUS_W-1:0] st;
		st = STATUS_OK;
		case (c.command)
			CMD_LOAD: begin
				if (pred_count >= DEPTH) begin
					st = STATUS_FULL;
				end else begin
					pred_stamps[pred_count] = c.amount_ns;
					pred_count++;
					pred_timer = '0;
					pred_frame = 0;
				end
			end
			CMD_CLEAR: begin
				pred_count = 0;
				pred_frame = 0;
				pred_timer = '0;
			end
			CMD_TICK: advance_timer(c.amount_ns);
			CMD_SEEK: begin
				if (pred_count != 0) begin
					pred_timer = c.amount_ns;
					pred_frame = find_frame(pred_timer, 0);
				end
			end
			CMD_NEXT: begin
				if (pred_count != 0) pred_frame = (pred_frame + 1) % pred_count;
			end
			CMD_PREV: begin
				if (pred_count != 0) begin
					if (pred_frame == 0 || pred_frame > pred_count) pred_frame = pred_count - 1;
					else pred_frame--;
				end
			end
			CMD_SET: begin
				if (c.frame_select < pred_count) pred_frame = c.frame_select;
				else st = STATUS_BAD_FRAME;
			end
			default: ;
		endcase
		r.frame_index = FRAME_W'(pred_frame);
		r.timer_ns = pred_timer;
		r.frame_offset_ns = frame_offset(pred_frame);
		r.entry_count = COUNT_OUT_W'(pred_count);
		r.status = st;
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned draw_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		else if (r < 90) return $urandom_range(1, 3);
		else if (r < 98) return $urandom_range(4, 15);
		else return $urandom_range(30, 200);
	endfunction

	function automatic void check_field(string name, logic [STAMP_W-1:0] want,
			logic [STAMP_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Command driver: one transaction per queued command, random gaps between them.
	int unsigned in_gap = 0;
	int unsigned in_burst = 0;
	seq_cmd_t    in_cur;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			in_gap = 0;
			in_burst = 0;
		end else begin
			if (s_tvalid && s_tready) result_q = {result_q, apply_command(in_cur)};
			if (!s_tvalid || s_tready) begin
				if (in_gap > 0) begin
					in_gap--;
					s_tvalid <= 1'b0;
				end else if (cmd_q.size() > 0) begin
					in_cur = cmd_q.pop_front();
					s_tdata <= {3'b000, in_cur.frame_select, in_cur.amount_ns, in_cur.command};
					s_tvalid <= 1'b1;
					if (in_burst > 0) begin
						in_burst--;
						in_gap = 0;
					end else begin
						in_gap = draw_gap();
						if ($urandom_range(0, 49) == 0) in_burst = $urandom_range(20, 80);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: random stalls, each transaction compared with the oldest prediction.
	int unsigned out_stall = 0;
	int unsigned out_burst = 0;
	seq_result_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			out_stall = 0;
			out_burst = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result transaction, expected none, actual %0h",
						$time, m_tdata);
					errors++;
				end else begin
					want = result_q.pop_front();
					check_field("frame_index", 64'(want.frame_index), 64'(m_tdata[9:0]));
					check_field("timer_ns", want.timer_ns, m_tdata[73:10]);
					check_field("frame_offset_ns", want.frame_offset_ns, m_tdata[137:74]);
					check_field("entry_count", 64'(want.entry_count), 64'(m_tdata[148:138]));
					check_field("status", 64'(want.status), 64'(m_tdata[150:149]));
				end
			end
			if (out_stall > 0) begin
				out_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (out_burst > 0) out_burst--;
				else if ($urandom_range(0, 99) == 0) out_burst = $urandom_range(20, 100);
				else if ($urandom_range(0, 3) == 0) out_stall = draw_gap();
			end
		end
	end

	// Watchdog over cycles without any transaction.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [STAMP_W-1:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [FRAME_W-1:0] rand_sel();
		return FRAME_W'($urandom_range(0, 1023));
	endfunction

	// Spacing of ascending stamps: equal, small, medium or very large.
	function automatic logic [STAMP_W-1:0] stamp_step();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) return '0;
		else if (r < 80) return 64'($urandom_range(1, 1000));
		else if (r < 95) return 64'($urandom_range(1000, 1000000));
		else return {24'd0, 8'($urandom_range(0, 255)), 32'($urandom())};
	endfunction

	task automatic add_cmd(logic [CMD_W-1:0] c, logic [STAMP_W-1:0] amt,
			logic [FRAME_W-1:0] sel);
		seq_cmd_t x;
		x.command = c;
		x.amount_ns = amt;
		x.frame_select = sel;
		cmd_q = {cmd_q, x};
	endtask

	// Blocks until every queued command is answered.
	task automatic wait_idle();
		while (cmd_q.size() != 0 || s_tvalid || result_q.size() != 0) @(posedge clk);
	endtask

	// One register write transaction, issued while the block is idle.
	task automatic write_reg(logic idx, logic val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_LOOPED) pred_looped = val;
		else pred_paused = val;
	endtask

	// Clear, an ascending table load, then playback commands mixed with some noise.
	task automatic run_sequence(int unsigned n_loads, int unsigned n_ops);
		logic [STAMP_W-1:0] stamp;
		logic [STAMP_W-1:0] first;
		logic [STAMP_W-1:0] dur;
		logic [STAMP_W-1:0] amt;
		logic [FRAME_W-1:0] sel;
		int unsigned k;
		int unsigned r;
		add_cmd(CMD_CLEAR, rand64(), rand_sel());
		first = ($urandom_range(0, 1) == 1) ? rand64() : 64'($urandom_range(0, 5000));
		stamp = first;
		for (k = 0; k < n_loads; k++) begin
			if (k > 0) stamp = stamp + stamp_step();
			add_cmd(CMD_LOAD, stamp, rand_sel());
		end
		dur = stamp - first;
		for (k = 0; k < n_ops; k++) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				r = $urandom_range(0, 99);
				if (r < 55) amt = 64'd1 + rand64() % (dur / 3 + 64'd1);
				else if (r < 65) amt = '0;
				else if (r < 75) amt = dur;
				else if (r < 82) amt = dur + 64'd1;
				else if (r < 88) amt = rand64();
				else if (r < 92) amt = MAX_NS;
				else amt = 64'($urandom_range(1, 10));
				add_cmd(CMD_TICK, amt, rand_sel());
			end else if (r < 52) begin
				r = $urandom_range(0, 99);
				if (r < 50) amt = (dur == MAX_NS) ? rand64() : rand64() % (dur + 64'd1);
				else if (r < 60) amt = '0;
				else if (r < 70) amt = dur;
				else amt = rand64();
				add_cmd(CMD_SEEK, amt, rand_sel());
			end else if (r < 62) begin
				add_cmd(CMD_NEXT, rand64(), rand_sel());
			end else if (r < 72) begin
				add_cmd(CMD_PREV, rand64(), rand_sel());
			end else if (r < 84) begin
				if ($urandom_range(0, 4) != 0) sel = FRAME_W'($urandom_range(0, n_loads - 1));
				else sel = rand_sel();
				add_cmd(CMD_SET, rand64(), sel);
			end else if (r < 88) begin
				add_cmd(CMD_NOP, rand64(), rand_sel());
			end else if (r < 95) begin
				amt = ($urandom_range(0, 1) == 1) ? rand64() : stamp + stamp_step();
				add_cmd(CMD_LOAD, amt, rand_sel());
			end else begin
				add_cmd(CMD_CLEAR, rand64(), rand_sel());
			end
		end
	endtask

	// Stimulus sequence and end of run.
	initial begin
		int p;
		int k;
		int unsigned budget;
		int unsigned n_loads;
		int unsigned n_ops;
		logic [STAMP_W-1:0] stamp;
		logic [STAMP_W-1:0] dur;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(CFG_LOOPED, 1'b0);
		write_reg(CFG_PAUSED, 1'b0);

		// Directed: empty table, a four-frame table, clamp, wrap of next and
		// previous, bad frame index, saturation and a descending stamp.
		add_cmd(CMD_TICK, 64'd500, '0);
		add_cmd(CMD_SEEK, 64'd500, '0);
		add_cmd(CMD_NEXT, '0, '0);
		add_cmd(CMD_PREV, '0, '0);
		add_cmd(CMD_NOP, MAX_NS, '1);
		add_cmd(CMD_LOAD, 64'd100, '0);
		add_cmd(CMD_LOAD, 64'd250, '0);
		add_cmd(CMD_LOAD, 64'd400, '0);
		add_cmd(CMD_LOAD, 64'd1000, '0);
		add_cmd(CMD_TICK, '0, '0);
		add_cmd(CMD_TICK, 64'd120, '0);
		add_cmd(CMD_TICK, 64'd2000, '0);
		add_cmd(CMD_SEEK, 64'd300, '0);
		add_cmd(CMD_NEXT, '0, '0);
		add_cmd(CMD_NEXT, '0, '0);
		add_cmd(CMD_PREV, '0, '0);
		add_cmd(CMD_SET, '0, 10'd3);
		add_cmd(CMD_SET, '0, '1);
		add_cmd(CMD_CLEAR, '0, '0);
		add_cmd(CMD_LOAD, 64'd7, '0);
		add_cmd(CMD_LOAD, 64'd7, '0);
		add_cmd(CMD_TICK, MAX_NS, '0);
		add_cmd(CMD_TICK, 64'd1, '0);
		add_cmd(CMD_LOAD, 64'd3, '0);
		add_cmd(CMD_SEEK, MAX_NS, '0);
		wait_idle();

		// Random phases over the register settings, mostly small tables.
		for (p = 0; p < RANDOM_PHASES; p++) begin
			write_reg(CFG_LOOPED, LOOP_PLAN[p]);
			write_reg(CFG_PAUSED, PAUSE_PLAN[p]);
			budget = 0;
			while (budget < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) n_loads = $urandom_range(13, 48);
				else n_loads = $urandom_range(1, 12);
				n_ops = $urandom_range(6, 20);
				run_sequence(n_loads, n_ops);
				budget += 1 + n_loads + n_ops;
			end
			wait_idle();
		end

		// Large table: searches and ticks across many entries.
		write_reg(CFG_LOOPED, 1'b0);
		write_reg(CFG_PAUSED, 1'b0);
		add_cmd(CMD_CLEAR, '0, '0);
		stamp = rand64() >> 1;
		for (k = 0; k < BIG_LOADS; k++) begin
			add_cmd(CMD_LOAD, stamp + 64'(k) * 64'd50 + 64'($urandom_range(0, 49)), rand_sel());
		end
		dur = 64'(BIG_LOADS - 1) * 64'd50 + 64'd49;
		add_cmd(CMD_SEEK, MAX_NS, rand_sel());
		add_cmd(CMD_SEEK, dur / 2, rand_sel());
		add_cmd(CMD_TICK, 64'd1, rand_sel());
		add_cmd(CMD_SET, rand64(), '1);
		add_cmd(CMD_NEXT, rand64(), rand_sel());
		add_cmd(CMD_PREV, rand64(), rand_sel());
		add_cmd(CMD_TICK, 64'($urandom_range(1, 4000)), rand_sel());
		add_cmd(CMD_TICK, dur, rand_sel());
		wait_idle();
		write_reg(CFG_LOOPED, 1'b1);
		add_cmd(CMD_SEEK, dur - 64'd20, rand_sel());
		add_cmd(CMD_TICK, 64'd400, rand_sel());
		add_cmd(CMD_TICK, dur, rand_sel());
		add_cmd(CMD_TICK, MAX_NS, rand_sel());
		add_cmd(CMD_SEEK, '0, rand_sel());
		add_cmd(CMD_LOAD, rand64(), rand_sel());
		wait_idle();

		// Settle time for any stray result transaction.
		repeat (1200) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/tfs_pkg.sv
sv/tfs_ram.sv
sv/tfs_rem.sv
sv/timestamp_frame_sequencer.sv
sim/tb_timestamp_frame_sequencer.sv
